/* rtl/core/huffman_tree_walk_decoder_assert.svh */
// assertion macros used by the decoder's walker module
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH

// same-cycle implication, checking suspended while reset is low
`define HTWD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htwd assertion failed");

// next-cycle implication, checking suspended while reset is low
`define HTWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htwd assertion failed");

`endif

/* rtl/core/htwd_pkg.sv */
package htwd_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_WRITE_NODE = 2'd0,
    OP_START      = 2'd1,
    OP_DECODE     = 2'd2
  } op_t;

  localparam int OP_W       = 2;
  localparam int SYM_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = 3;
  localparam int SECT_W     = 32;
  localparam int LEAF_CNT_W = 9;

  localparam logic [BIT_IDX_W-1:0]  TOP_BIT        = 3'd7;
  localparam logic [LEAF_CNT_W-1:0] LEAF_CNT_RESET = 9'd2;
  localparam logic [LEAF_CNT_W:0]   MIN_LEAVES     = 10'd2;

  // configuration register map
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_ADDR_W = CFG_IDX_W + 2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT = 1'd0;

endpackage

/* rtl/core/htwd_node_ram.sv */
module htwd_node_ram #(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 26
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/htwd_walker.sv */
module htwd_walker #(
  parameter int IDX_W = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [htwd_pkg::OP_W-1:0]   in_operation,
  input  logic [IDX_W-1:0]            in_node_index,
  input  logic [IDX_W-1:0]            in_left_child,
  input  logic [IDX_W-1:0]            in_right_child,
  input  logic [htwd_pkg::SYM_W-1:0]  in_leaf_symbol,
  input  logic [htwd_pkg::SECT_W-1:0] in_section_length,
  input  logic [htwd_pkg::BYTE_W-1:0] in_coded_byte,
  input  logic [IDX_W-1:0]            root_i,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [htwd_pkg::SYM_W-1:0]  out_symbol,
  output logic                        out_last_of_byte,
  output logic                        out_section_done
);

`include "huffman_tree_walk_decoder_assert.svh"

  localparam int ENTRY_W = 2 * IDX_W + htwd_pkg::SYM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_TEST,
    S_FLUSH
  } state_t;

  state_t                           state_r, state_nxt;
  logic [htwd_pkg::BYTE_W-1:0]      byte_r, byte_nxt;
  logic [htwd_pkg::BIT_IDX_W-1:0]   bit_r, bit_nxt;
  logic [htwd_pkg::SECT_W-1:0]      remain_r, remain_nxt;
  logic [IDX_W-1:0]                 pos_r, pos_nxt;
  logic                             pend_valid_r, pend_valid_nxt;
  logic [htwd_pkg::SYM_W-1:0]       pend_sym_r, pend_sym_nxt;
  logic                             pend_done_r, pend_done_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [htwd_pkg::SYM_W-1:0]       out_symbol_r, out_symbol_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_done_r, out_done_nxt;

  logic                             wr_en;
  logic [ENTRY_W-1:0]               wr_data;
  logic                             rd_en;
  logic [IDX_W-1:0]                 rd_addr;
  logic [ENTRY_W-1:0]               rd_data;
  logic [IDX_W-1:0]                 rd_left, rd_right;
  logic [htwd_pkg::SYM_W-1:0]       rd_sym;
  logic                             leaf;
  logic [htwd_pkg::BIT_IDX_W-1:0]   bit_dec;
  logic [IDX_W-1:0]                 child_cur, child_next;
  logic [htwd_pkg::SECT_W-1:0]      remain_dec;
  logic                             out_free;
  logic                             out_load;
  logic                             leaf_take;

  assign wr_data = {in_left_child, in_right_child, in_leaf_symbol};

  htwd_node_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_node_index),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_left    = rd_data[ENTRY_W-1 -: IDX_W];
  assign rd_right   = rd_data[htwd_pkg::SYM_W +: IDX_W];
  assign rd_sym     = rd_data[htwd_pkg::SYM_W-1:0];
  assign leaf       = (rd_left == '0) && (rd_right == '0);
  assign bit_dec    = bit_r - 3'd1;
  assign child_cur  = byte_r[bit_r] ? rd_right : rd_left;
  assign child_next = byte_r[bit_dec] ? rd_right : rd_left;
  assign remain_dec = remain_r - 32'd1;
  assign out_free   = !out_valid_r || !out_stall;
  assign leaf_take  = (state_r == S_TEST) && leaf && (!pend_valid_r || out_free);

  always_comb begin
    state_nxt      = state_r;
    byte_nxt       = byte_r;
    bit_nxt        = bit_r;
    remain_nxt     = remain_r;
    pos_nxt        = pos_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    pend_done_nxt  = pend_done_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = pos_r;
    out_load       = 1'b0;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            htwd_pkg::OP_WRITE_NODE: begin
              wr_en = 1'b1;
            end
            htwd_pkg::OP_START: begin
              remain_nxt = in_section_length;
              pos_nxt    = root_i;
            end
            htwd_pkg::OP_DECODE: begin
              byte_nxt = in_coded_byte;
              bit_nxt  = htwd_pkg::TOP_BIT;
              if (remain_r != '0) begin
                state_nxt = S_LOAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        rd_en     = 1'b1;
        rd_addr   = pos_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        rd_en     = 1'b1;
        rd_addr   = child_cur;
        pos_nxt   = child_cur;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (leaf) begin
          if (leaf_take) begin
            // older symbol of this byte goes out, not the last one
            if (pend_valid_r) begin
              out_load       = 1'b1;
              out_symbol_nxt = pend_sym_r;
              out_last_nxt   = 1'b0;
              out_done_nxt   = pend_done_r;
            end
            pend_valid_nxt = 1'b1;
            pend_sym_nxt   = rd_sym;
            pend_done_nxt  = (remain_dec == '0);
            remain_nxt     = remain_dec;
            pos_nxt        = root_i;
            if ((bit_r == '0) || (remain_dec == '0)) begin
              state_nxt = S_FLUSH;
            end else begin
              bit_nxt   = bit_dec;
              state_nxt = S_LOAD;
            end
          end
        end else if (bit_r == '0) begin
          state_nxt = S_FLUSH;
        end else begin
          bit_nxt = bit_dec;
          rd_en   = 1'b1;
          rd_addr = child_next;
          pos_nxt = child_next;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_load       = 1'b1;
          out_symbol_nxt = pend_sym_r;
          out_last_nxt   = 1'b1;
          out_done_nxt   = pend_done_r;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      remain_r     <= '0;
      pos_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      remain_r     <= remain_nxt;
      pos_r        <= pos_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    bit_r        <= bit_nxt;
    pend_sym_r   <= pend_sym_nxt;
    pend_done_r  <= pend_done_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_last_of_byte = out_last_r;
  assign out_section_done = out_done_r;

  `HTWD_ASSERT_NOW(a_no_pend_in_idle, clk, rst_n, state_r == S_IDLE, !pend_valid_r)
  `HTWD_ASSERT_NOW(a_load_into_free_slot, clk, rst_n, out_load, out_free)
  `HTWD_ASSERT_NOW(a_done_is_last, clk, rst_n, out_valid_r && out_done_r, out_last_r)
  `HTWD_ASSERT_NEXT(a_leaf_back_to_root, clk, rst_n, leaf_take, pos_r == root_i)

endmodule

/* rtl/core/huffman_tree_walk_decoder.sv */
// channel   | beat moves                                   | flow control
// ----------+----------------------------------------------+--------------------------
// in_       | one item: operation and its node/section/byte | in_valid / in_stall
// out_      | one decoded symbol with its two flags         | out_valid / out_stall
// apb       | leaf_count write or read at paddr 0           | psel/penable, pready = 1
//
// write-node, start, unused and section-exhausted decode beats are taken without a stall
// other decode beats stall the input while the byte is walked, at a cost set by the node
//   table's single read port: one read per code bit, plus a root reload and a first-step
//   read after each leaf that does not end the beat
// a held out beat freezes the walk only when a finished symbol has nowhere to go
// rst_n is synchronous; the node table has no reset and is valid once written
module huffman_tree_walk_decoder #(
  parameter int MAX_LEAVES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [htwd_pkg::OP_W-1:0]       in_operation,
  input  logic [$clog2(2*MAX_LEAVES)-1:0] in_node_index,
  input  logic [$clog2(2*MAX_LEAVES)-1:0] in_left_child,
  input  logic [$clog2(2*MAX_LEAVES)-1:0] in_right_child,
  input  logic [htwd_pkg::SYM_W-1:0]      in_leaf_symbol,
  input  logic [htwd_pkg::SECT_W-1:0]     in_section_length,
  input  logic [htwd_pkg::BYTE_W-1:0]     in_coded_byte,
  // symbol channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [htwd_pkg::SYM_W-1:0]      out_symbol,
  output logic                            out_last_of_byte,
  output logic                            out_section_done,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [htwd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [htwd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [htwd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  // node index width follows from the largest tree (2n-1 nodes)
  localparam int IDX_W = $clog2(2 * MAX_LEAVES);
  localparam logic [htwd_pkg::LEAF_CNT_W:0] MAX_N = (htwd_pkg::LEAF_CNT_W + 1)'(MAX_LEAVES);

  logic [htwd_pkg::LEAF_CNT_W-1:0]  leaf_count_r, leaf_count_nxt;
  logic [htwd_pkg::CFG_IDX_W-1:0]   reg_idx;
  logic                             cfg_wr;
  logic [htwd_pkg::LEAF_CNT_W:0]    leaf_wide;
  logic [htwd_pkg::LEAF_CNT_W:0]    leaf_clamp;
  logic [htwd_pkg::LEAF_CNT_W+1:0]  root_full;
  logic [IDX_W-1:0]                 root;

  // register index sits above the byte offset
  assign reg_idx = paddr[htwd_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    leaf_count_nxt = leaf_count_r;
    if (cfg_wr && (reg_idx == htwd_pkg::REG_LEAF_COUNT)) begin
      leaf_count_nxt = pwdata[htwd_pkg::LEAF_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= htwd_pkg::LEAF_CNT_RESET;
    end else begin
      leaf_count_r <= leaf_count_nxt;
    end
  end

  // reads of unmapped addresses return zero
  assign prdata = (reg_idx == htwd_pkg::REG_LEAF_COUNT) ?
                  htwd_pkg::CFG_DATA_W'(leaf_count_r) : '0;

  // root = 2n-1 with n held to the supported range
  always_comb begin
    leaf_wide = {1'b0, leaf_count_r};
    if (leaf_wide < htwd_pkg::MIN_LEAVES) begin
      leaf_clamp = htwd_pkg::MIN_LEAVES;
    end else if (leaf_wide > MAX_N) begin
      leaf_clamp = MAX_N;
    end else begin
      leaf_clamp = leaf_wide;
    end
    root_full = {leaf_clamp, 1'b0} - (htwd_pkg::LEAF_CNT_W + 2)'(1);
  end

  assign root = root_full[IDX_W-1:0];

  // sequencer, node table and output register
  htwd_walker #(
    .IDX_W (IDX_W)
  ) u_walker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_node_index     (in_node_index),
    .in_left_child     (in_left_child),
    .in_right_child    (in_right_child),
    .in_leaf_symbol    (in_leaf_symbol),
    .in_section_length (in_section_length),
    .in_coded_byte     (in_coded_byte),
    .root_i            (root),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol        (out_symbol),
    .out_last_of_byte  (out_last_of_byte),
    .out_section_done  (out_section_done)
  );

endmodule
